/* rtl/vfc_pkg.sv */
package vfc_pkg;

    // Default chunk geometry and stored type width
    localparam int DEF_CHUNK_SIDE = 16;
    localparam int DEF_CHUNK_TALL = 64;
    localparam int DEF_TYPE_BITS  = 6;

    // Configuration register indexes
    localparam int CFG_IDX_W = 2;
    localparam logic [CFG_IDX_W-1:0] REG_TRANSPARENT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_AIR_TYPE    = 2'd1;

    // Request codes
    localparam logic REQ_WRITE = 1'b0;
    localparam logic REQ_QUERY = 1'b1;

    // Face directions, in checking order
    localparam logic [2:0] DIR_FRONT  = 3'd0;
    localparam logic [2:0] DIR_BACK   = 3'd1;
    localparam logic [2:0] DIR_LEFT   = 3'd2;
    localparam logic [2:0] DIR_RIGHT  = 3'd3;
    localparam logic [2:0] DIR_TOP    = 3'd4;
    localparam logic [2:0] DIR_BOTTOM = 3'd5;

    localparam int NUM_DIRS = 6;

    typedef struct packed {
        logic       req_type;
        logic [3:0] voxel_x;
        logic [5:0] voxel_y;
        logic [3:0] voxel_z;
        logic [5:0] new_type;
    } vfc_in_t;

    typedef struct packed {
        logic [2:0] face_dir;
        logic [3:0] face_x;
        logic [5:0] face_y;
        logic [3:0] face_z;
        logic [5:0] face_block;
        logic       last_face;
    } vfc_out_t;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOK,
        ST_EMIT
    } vfc_state_t;

    typedef struct packed {
        logic clear_en;
        logic accept;
        logic look;
        logic eval_center;
        logic load_face;
    } vfc_cmd_t;

    typedef struct packed {
        logic clear_done;
        logic query_ok;
        logic center_step;
        logic look_done;
        logic opaque;
        logic faces_none;
        logic out_free;
        logic face_last;
    } vfc_status_t;

endpackage

/* rtl/voxel_face_culler_top.sv */
// Channel | Ports                                  | Direction | Moves
// s       | s_valid, s_ready, s_data               | in        | write or query item
// m       | m_valid, m_ready, m_data               | out       | one face item
// cfg     | cfg_valid, cfg_ready, cfg_index, cfg_data | in     | register write
//
// A write item is stored as it is accepted. A query item is accepted, then the voxel and
// its six neighbours are read from the single-port store (one read per cycle), then the
// faces go out through the output register, one per cycle while m is not stalled; faces 0 to 6.
// A transparent voxel ends the query once the voxel itself is read, before any face is checked.
// After reset a clearing pass writes type 0, the reset air type, into every store entry, one per cycle
// (CHUNK_SIDE*CHUNK_SIDE*CHUNK_TALL entries, 16384 by default); s_ready stays low meanwhile.
// Reset is synchronous, active low. cfg is always ready. A stalled m side holds the
// face in the output register and freezes face emission.
module voxel_face_culler_top
    import vfc_pkg::*;
#(
    parameter int CHUNK_SIDE = DEF_CHUNK_SIDE,
    parameter int CHUNK_TALL = DEF_CHUNK_TALL,
    parameter int TYPE_BITS  = DEF_TYPE_BITS
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  logic                 s_valid,
    output logic                 s_ready,
    input  vfc_in_t              s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output vfc_out_t             m_data,
    input  logic                 cfg_valid,
    output logic                 cfg_ready,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [63:0]          cfg_data
);

    vfc_cmd_t    cmd;
    vfc_status_t status;

    // Accept configuration writes at any time; the user writes only while idle.
    assign cfg_ready = 1'b1;

    // Sequence clearing, item acceptance, the neighbour read walk and face emission.
    vfc_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .status  (status),
        .cmd     (cmd)
    );

    // Hold the voxel store, configuration, face mask and output register.
    vfc_datapath #(
        .CHUNK_SIDE (CHUNK_SIDE),
        .CHUNK_TALL (CHUNK_TALL),
        .TYPE_BITS  (TYPE_BITS)
    ) u_datapath (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cmd       (cmd),
        .status    (status)
    );

endmodule

/* rtl/vfc_ctrl.sv */
module vfc_ctrl
    import vfc_pkg::*;
(
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_valid,
    output logic        s_ready,
    input  vfc_status_t status,
    output vfc_cmd_t    cmd
);

    vfc_state_t state_reg, state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_CLEAR;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next = state_reg;
        case (state_reg)
            ST_CLEAR: begin
                if (status.clear_done) begin
                    state_next = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (s_valid && status.query_ok) begin
                    state_next = ST_LOOK;
                end
            end
            ST_LOOK: begin
                if (status.center_step && !status.opaque) begin
                    state_next = ST_IDLE;
                end else if (status.look_done) begin
                    state_next = status.faces_none ? ST_IDLE : ST_EMIT;
                end
            end
            ST_EMIT: begin
                if (status.out_free && status.face_last) begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_CLEAR;
        endcase
    end

    always_comb begin
        cmd     = '0;
        s_ready = 1'b0;
        case (state_reg)
            ST_CLEAR: begin
                cmd.clear_en = 1'b1;
            end
            ST_IDLE: begin
                s_ready    = 1'b1;
                cmd.accept = s_valid;
            end
            ST_LOOK: begin
                cmd.look        = 1'b1;
                cmd.eval_center = status.center_step;
            end
            ST_EMIT: begin
                cmd.load_face = status.out_free;
            end
            default: begin
                cmd = '0;
            end
        endcase
    end

endmodule

/* rtl/vfc_datapath.sv */
module vfc_datapath
    import vfc_pkg::*;
#(
    parameter int CHUNK_SIDE = DEF_CHUNK_SIDE,
    parameter int CHUNK_TALL = DEF_CHUNK_TALL,
    parameter int TYPE_BITS  = DEF_TYPE_BITS
) (
    input  logic                 aclk,
    input  logic                 aresetn,
    input  vfc_in_t              s_data,
    output logic                 m_valid,
    input  logic                 m_ready,
    output vfc_out_t             m_data,
    input  logic                 cfg_valid,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [63:0]          cfg_data,
    input  vfc_cmd_t             cmd,
    output vfc_status_t          status
);

    localparam int DEPTH  = CHUNK_SIDE * CHUNK_SIDE * CHUNK_TALL;
    localparam int ADDR_W = $clog2(DEPTH);

    function automatic logic [ADDR_W-1:0] idx_of(
        input logic [4:0] x,
        input logic [6:0] y,
        input logic [4:0] z
    );
        idx_of = ADDR_W'(x) + ADDR_W'(CHUNK_SIDE)
               * (ADDR_W'(z) + ADDR_W'(CHUNK_SIDE) * ADDR_W'(y));
    endfunction

    logic [63:0]          mask_cfg_reg;
    logic [5:0]           air_reg;
    vfc_in_t              item_reg;
    logic [2:0]           step_reg;
    logic [NUM_DIRS-1:0]  faces_reg, faces_next;
    logic [TYPE_BITS-1:0] type_reg;
    logic [TYPE_BITS-1:0] rd_data_reg;
    logic [ADDR_W-1:0]    clr_addr_reg;
    logic                 m_valid_reg;
    vfc_out_t             m_data_reg;

    logic [TYPE_BITS-1:0] mem [DEPTH];

    logic                 in_range;
    logic                 mem_we;
    logic [ADDR_W-1:0]    mem_addr;
    logic [TYPE_BITS-1:0] mem_wdata;
    logic [2:0]           dir_rd, dir_ev;
    logic [4:0]           ax, az;
    logic [6:0]           ay;
    logic                 at_side, at_end, nbr_eval, face_bit;
    logic [NUM_DIRS-1:0]  pick;
    logic [2:0]           pick_dir;

    // configuration registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mask_cfg_reg <= 64'd1;
            air_reg      <= 6'd0;
        end else if (cfg_valid) begin
            case (cfg_index)
                REG_TRANSPARENT: mask_cfg_reg <= cfg_data;
                REG_AIR_TYPE:    air_reg      <= cfg_data[5:0];
                default:         ;
            endcase
        end
    end

    assign in_range = (32'(s_data.voxel_x) < CHUNK_SIDE)
                   && (32'(s_data.voxel_z) < CHUNK_SIDE)
                   && (32'(s_data.voxel_y) < CHUNK_TALL);

    // neighbour address, clamped to the voxel itself when it falls outside
    assign dir_rd = step_reg - 3'd1;
    always_comb begin
        ax = 5'(item_reg.voxel_x);
        ay = 7'(item_reg.voxel_y);
        az = 5'(item_reg.voxel_z);
        case (dir_rd)
            DIR_FRONT:  if (32'(item_reg.voxel_z) + 1 < CHUNK_SIDE) az = az + 5'd1;
            DIR_BACK:   if (item_reg.voxel_z != 4'd0) az = az - 5'd1;
            DIR_LEFT:   if (item_reg.voxel_x != 4'd0) ax = ax - 5'd1;
            DIR_RIGHT:  if (32'(item_reg.voxel_x) + 1 < CHUNK_SIDE) ax = ax + 5'd1;
            DIR_TOP:    if (32'(item_reg.voxel_y) + 1 < CHUNK_TALL) ay = ay + 7'd1;
            DIR_BOTTOM: if (item_reg.voxel_y != 6'd0) ay = ay - 7'd1;
            default:    ;
        endcase
    end

    always_comb begin
        mem_we    = 1'b0;
        mem_wdata = s_data.new_type[TYPE_BITS-1:0];
        mem_addr  = idx_of(ax, ay, az);
        if (cmd.clear_en) begin
            mem_we    = 1'b1;
            mem_wdata = '0;
            mem_addr  = clr_addr_reg;
        end else if (cmd.accept) begin
            mem_we   = (s_data.req_type == REQ_WRITE) && in_range;
            mem_addr = idx_of(5'(s_data.voxel_x), 7'(s_data.voxel_y), 5'(s_data.voxel_z));
        end
    end

    always_ff @(posedge aclk) begin
        if (mem_we) begin
            mem[mem_addr] <= mem_wdata;
        end else begin
            rd_data_reg <= mem[mem_addr];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            clr_addr_reg <= '0;
        end else if (cmd.clear_en) begin
            clr_addr_reg <= clr_addr_reg + ADDR_W'(1);
        end
    end

    // evaluate the neighbour read in the previous step
    assign dir_ev   = step_reg - 3'd2;
    assign nbr_eval = cmd.look && (step_reg >= 3'd2);
    always_comb begin
        at_side = 1'b0;
        at_end  = 1'b0;
        case (dir_ev)
            DIR_FRONT:  at_side = 32'(item_reg.voxel_z) + 1 >= CHUNK_SIDE;
            DIR_BACK:   at_side = item_reg.voxel_z == 4'd0;
            DIR_LEFT:   at_side = item_reg.voxel_x == 4'd0;
            DIR_RIGHT:  at_side = 32'(item_reg.voxel_x) + 1 >= CHUNK_SIDE;
            DIR_TOP:    at_end  = 32'(item_reg.voxel_y) + 1 >= CHUNK_TALL;
            DIR_BOTTOM: at_end  = item_reg.voxel_y == 6'd0;
            default:    ;
        endcase
    end
    assign face_bit = !at_end && (at_side || (6'(rd_data_reg) == air_reg));

    // lowest pending face goes out first
    always_comb begin
        pick     = '0;
        pick_dir = DIR_FRONT;
        for (int i = NUM_DIRS - 1; i >= 0; i--) begin
            if (faces_reg[i]) begin
                pick     = NUM_DIRS'(1) << i;
                pick_dir = 3'(i);
            end
        end
    end

    always_comb begin
        faces_next = faces_reg;
        if (cmd.accept) begin
            faces_next = '0;
        end else if (nbr_eval && face_bit) begin
            faces_next = faces_reg | (NUM_DIRS'(1) << dir_ev);
        end else if (cmd.load_face) begin
            faces_next = faces_reg & ~pick;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            step_reg  <= '0;
            faces_reg <= '0;
        end else begin
            faces_reg <= faces_next;
            if (cmd.accept) begin
                step_reg <= '0;
            end else if (cmd.look) begin
                step_reg <= step_reg + 3'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.accept) begin
            item_reg <= s_data;
        end
        if (cmd.eval_center) begin
            type_reg <= rd_data_reg;
        end
    end

    // output register
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (cmd.load_face) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load_face) begin
            m_data_reg.face_dir   <= pick_dir;
            m_data_reg.face_x     <= item_reg.voxel_x;
            m_data_reg.face_y     <= item_reg.voxel_y;
            m_data_reg.face_z     <= item_reg.voxel_z;
            m_data_reg.face_block <= 6'(type_reg);
            m_data_reg.last_face  <= (faces_reg & ~pick) == '0;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    assign status.clear_done  = clr_addr_reg == ADDR_W'(DEPTH - 1);
    assign status.query_ok    = (s_data.req_type == REQ_QUERY) && in_range;
    assign status.center_step = step_reg == 3'd1;
    assign status.look_done   = step_reg == 3'd7;
    assign status.opaque      = !mask_cfg_reg[6'(rd_data_reg)];
    assign status.faces_none  = faces_next == '0;
    assign status.out_free    = !m_valid_reg || m_ready;
    assign status.face_last   = (faces_reg & ~pick) == '0;

endmodule
